>>> hw/rtl/i2da_pkg.sv
// Package for the integer to decimal ASCII converter: word types, character
// constants and the microcode ROM of the step sequencer.
// No dependencies.
package i2da_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int DIGIT_COUNT = 10;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'd45;

   // input word: number and signed-mode flag
   typedef struct packed {
      logic [WORD_WIDTH-1:0] value;
      logic                  is_signed;
   } req_word_type;

   // result word: one character
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last;
   } rsp_word_type;

   // microprogram addresses
   typedef logic [1:0] step_type;
   localparam step_type STEP_SIGN   = 2'd0;
   localparam step_type STEP_DABBLE = 2'd1;
   localparam step_type STEP_SKIP   = 2'd2;
   localparam step_type STEP_EMIT   = 2'd3;

   // branch conditions tested by a control word
   typedef enum logic [1:0] {
      JMP_NEVER       = 2'd0,
      JMP_BITS_LEFT   = 2'd1,
      JMP_LEAD_ZERO   = 2'd2,
      JMP_DIGITS_LEFT = 2'd3
   } jump_cond_type;

   // one control word
   typedef struct packed {
      logic          do_sign;
      logic          do_dabble;
      logic          do_skip;
      logic          do_emit;
      logic          fin;
      jump_cond_type jcond;
      step_type      target;
   } uword_type;

   // microcode ROM: sign, 32 shift-add-3 steps, drop leading zeros, emit
   function automatic uword_type ucode_rom(input step_type pc);
      uword_type w;
      w = '0;
      case (pc)
         STEP_SIGN: begin
            w.do_sign = 1'b1;
            w.jcond   = JMP_NEVER;
            w.target  = STEP_SIGN;
         end
         STEP_DABBLE: begin
            w.do_dabble = 1'b1;
            w.jcond     = JMP_BITS_LEFT;
            w.target    = STEP_DABBLE;
         end
         STEP_SKIP: begin
            w.do_skip = 1'b1;
            w.jcond   = JMP_LEAD_ZERO;
            w.target  = STEP_SKIP;
         end
         STEP_EMIT: begin
            w.do_emit = 1'b1;
            w.fin     = 1'b1;
            w.jcond   = JMP_DIGITS_LEFT;
            w.target  = STEP_EMIT;
         end
         default: begin
            w = '0;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/integer_to_decimal_ascii.sv
// Integer to decimal ASCII converter: busy after an accepted word while it runs
// 1 sign step, 32 shift-add-3 steps and 11 steps to drop zeros and emit.
// A new word is taken only while busy is low, so not before the last one is done.
// Characters leave from an output register, the digits one per cycle; the receiver
// cannot stall. Reset clears the sequencer and the result strobe.
// Uses i2da_pkg for word types, constants and the microcode ROM.
module integer_to_decimal_ascii (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  i2da_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output i2da_pkg::rsp_word_type rsp_word
);

   localparam int BCD_W     = 4 * i2da_pkg::DIGIT_COUNT;
   localparam int BIT_CNT_W = $clog2(i2da_pkg::WORD_WIDTH);
   localparam int IDX_W     = $clog2(i2da_pkg::DIGIT_COUNT);
   localparam logic [BIT_CNT_W-1:0] BITS_LAST = BIT_CNT_W'(i2da_pkg::WORD_WIDTH - 1);
   localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(i2da_pkg::DIGIT_COUNT - 1);

   logic                           busy_ff, busy_in;
   i2da_pkg::step_type             pc_ff, pc_in;
   logic                           neg_ff, neg_in;
   logic [i2da_pkg::WORD_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]               bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   i2da_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   i2da_pkg::uword_type            uw;
   logic [BCD_W-1:0]               bcd_adj;
   logic [3:0]                     top_digit;
   logic                           lead_zero;
   logic                           digits_left;
   logic                           jump;

   assign uw          = i2da_pkg::ucode_rom(pc_ff);
   assign top_digit   = bcd_ff[BCD_W-1 -: 4];
   assign digits_left = (idx_ff != IDX_LAST);
   assign lead_zero   = (top_digit == 4'd0) && digits_left;

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < i2da_pkg::DIGIT_COUNT; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                         : bcd_ff[4*d +: 4];
      end
   end

   // branch condition of the current control word
   always_comb begin
      case (uw.jcond)
         i2da_pkg::JMP_NEVER:       jump = 1'b0;
         i2da_pkg::JMP_BITS_LEFT:   jump = (bit_cnt_ff != BITS_LAST);
         i2da_pkg::JMP_LEAD_ZERO:   jump = lead_zero;
         i2da_pkg::JMP_DIGITS_LEFT: jump = digits_left;
         default:                   jump = 1'b0;
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in    = 1'b1;
            pc_in      = i2da_pkg::STEP_SIGN;
            neg_in     = req_word.is_signed && req_word.value[i2da_pkg::WORD_WIDTH-1];
            mag_in     = neg_in ? (~req_word.value + 1'b1) : req_word.value;
            bcd_in     = '0;
            bit_cnt_in = '0;
            idx_in     = '0;
         end
      end else begin
         // advance the step counter
         if (jump) begin
            pc_in = uw.target;
         end else if (uw.fin) begin
            busy_in = 1'b0;
         end else begin
            pc_in = pc_ff + 2'd1;
         end
         // emit the minus sign
         if (uw.do_sign && neg_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_word_in.char_code = i2da_pkg::CH_MINUS;
            rsp_word_in.last      = 1'b0;
         end
         // shift one binary bit into the BCD register
         if (uw.do_dabble) begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[i2da_pkg::WORD_WIDTH-1]};
            mag_in     = {mag_ff[i2da_pkg::WORD_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
         end
         // drop a leading zero digit
         if (uw.do_skip && lead_zero) begin
            bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
            idx_in = idx_ff + 1'b1;
         end
         // emit the top digit
         if (uw.do_emit) begin
            rsp_valid_in          = 1'b1;
            rsp_word_in.char_code = i2da_pkg::CH_ZERO + {4'd0, top_digit};
            rsp_word_in.last      = !digits_left;
            bcd_in                = {bcd_ff[BCD_W-5:0], 4'd0};
            idx_in                = idx_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= i2da_pkg::STEP_SIGN;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // a character only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy_ff))
      else $error("result without work in progress");

   // work ends only with a last character
   a_done_with_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy_ff) && !$past(reset)) |-> (rsp_valid_ff && rsp_word_ff.last))
      else $error("work ended without a last character");

   // digit pointer stays within the BCD register while busy
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= IDX_LAST))
      else $error("digit index out of range");

   // only '-' or a decimal digit leaves the block
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_word_ff.char_code == i2da_pkg::CH_MINUS) ||
                        ((rsp_word_ff.char_code >= i2da_pkg::CH_ZERO) &&
                         (rsp_word_ff.char_code <= i2da_pkg::CH_ZERO + 8'd9))))
      else $error("character outside minus and digits");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for integer_to_decimal_ascii: directed edge values, then random
// words under several sender idle settings, each character checked against typed text or a
// local predictor. Depends on i2da_pkg and the integer_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int DECIMAL_RADIX = 10;
   localparam int DIRECTED_ROWS = 20;
   localparam int PHASE_COUNT   = 3;
   localparam int PHASE_ITEMS   = 154;
   localparam int TAIL_CYCLES   = 60;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int NO_TYPED_ROW  = -1;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   i2da_pkg::req_word_type req_word;
   logic                   rsp_valid;
   i2da_pkg::rsp_word_type rsp_word;

   // characters still owed by the block, oldest first
   i2da_pkg::rsp_word_type pending_chars[$];
   // directed row whose typed text is the expectation for the word on req_word
   int           typed_row;
   int           failures;
   int           numbers_taken;
   int           negatives_taken;
   int           chars_checked;

   // directed words; an empty text means the predictor supplies the expectation
   i2da_pkg::req_word_type directed_word [DIRECTED_ROWS] = '{
      {32'd0,          1'b0}, {32'd0,          1'b1}, {32'd1,          1'b0},
      {32'd9,          1'b1}, {32'd10,         1'b0}, {32'hFFFF_FFFF,  1'b0},
      {32'hFFFF_FFFF,  1'b1}, {32'h8000_0000,  1'b1}, {32'h8000_0000,  1'b0},
      {32'h7FFF_FFFF,  1'b1}, {32'h8000_0001,  1'b1}, {32'hFFFF_FFF6,  1'b1},
      {32'd1000000000, 1'b0}, {32'd999999999,  1'b1}, {32'd4000000000, 1'b1},
      {32'h1234_5678,  1'b0}, {32'hAAAA_AAAA,  1'b1}, {32'h5555_5555,  1'b0},
      {32'd100,        1'b1}, {32'hFFFF_FC18,  1'b1}
   };
   string directed_text [DIRECTED_ROWS] = '{
      "0", "0", "1",
      "9", "10", "4294967295",
      "-1", "-2147483648", "2147483648",
      "2147483647", "-2147483647", "-10",
      "1000000000", "", "",
      "", "", "",
      "100", "-1000"
   };

   integer_to_decimal_ascii uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // queue the decimal text of one word: optional minus, then digits most significant first
   function automatic void push_decimal_chars(input i2da_pkg::req_word_type w);
      logic [i2da_pkg::WORD_WIDTH-1:0] magnitude;
      logic [i2da_pkg::CHAR_WIDTH-1:0] digit_chars [i2da_pkg::DIGIT_COUNT];
      int                              digit_total;
      int                              i;
      magnitude = w.value;
      if (w.is_signed && w.value[i2da_pkg::WORD_WIDTH-1]) begin
         magnitude = ~w.value + 1'b1;
         pending_chars.push_back('{char_code: i2da_pkg::CH_MINUS, last: 1'b0});
      end
      digit_total = 0;
      do begin
         digit_chars[digit_total] = i2da_pkg::CH_ZERO +
                                    i2da_pkg::CHAR_WIDTH'(magnitude % DECIMAL_RADIX);
         magnitude = magnitude / DECIMAL_RADIX;
         digit_total++;
      end while (magnitude != 0);
      for (i = digit_total - 1; i >= 0; i--) begin
         pending_chars.push_back('{char_code: digit_chars[i], last: (i == 0)});
      end
   endfunction

   // check each character against the oldest expectation, then book any word taken
   always @(posedge clock) begin
      i2da_pkg::rsp_word_type want;
      int                     i;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_chars.size() == 0) begin
               $display("%0t: unexpected character %h last %b", $time,
                        rsp_word.char_code, rsp_word.last);
               failures++;
            end else begin
               want = pending_chars.pop_front();
               chars_checked++;
               if (rsp_word.char_code !== want.char_code) begin
                  $display("%0t: char_code expected %h actual %h", $time,
                           want.char_code, rsp_word.char_code);
                  failures++;
               end
               if (rsp_word.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last,
                           rsp_word.last);
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            numbers_taken++;
            if (req_word.is_signed && req_word.value[i2da_pkg::WORD_WIDTH-1]) begin
               negatives_taken++;
            end
            if (typed_row != NO_TYPED_ROW && directed_text[typed_row].len() != 0) begin
               for (i = 0; i < directed_text[typed_row].len(); i++) begin
                  pending_chars.push_back('{char_code: directed_text[typed_row][i],
                                            last: (i == directed_text[typed_row].len() - 1)});
               end
            end else begin
               push_decimal_chars(req_word);
            end
         end
      end
   end

   // hold one word until taken, then idle the sender for a random stretch
   task automatic send_word(input i2da_pkg::req_word_type w, input int row, input int idle_pct);
      int gap;
      req_word  <= w;
      start     <= 1'b1;
      typed_row <= row;
      do @(posedge clock); while (busy);
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start     <= 1'b0;
         req_word  <= '{value: $urandom, is_signed: 1'($urandom)};
         typed_row <= NO_TYPED_ROW;
         repeat (gap) @(posedge clock);
      end
   endtask

   // pause the sender until every owed character has come out
   task automatic drain_chars();
      start     <= 1'b0;
      typed_row <= NO_TYPED_ROW;
      @(negedge clock);
      while (pending_chars.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int                     phase_idle [PHASE_COUNT];
      int                     phase;
      int                     n;
      int                     k;
      int                     idle_pct;
      int unsigned            power;
      i2da_pkg::req_word_type w;
      int                     waited;

      phase_idle = '{0, 85, 17};
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      typed_row = NO_TYPED_ROW;
      failures = 0;
      numbers_taken = 0;
      negatives_taken = 0;
      chars_checked = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: zero, extremes, most negative value, digit-count boundaries
      for (n = 0; n < DIRECTED_ROWS; n++) begin
         send_word(directed_word[n], n, 0);
      end
      drain_chars();

      // random words, mostly shaped toward boundaries and varied digit counts
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         for (n = 0; n < PHASE_ITEMS; n++) begin
            w.is_signed = 1'($urandom);
            case ($urandom_range(5))
               0: w.value = $urandom;
               1: w.value = $urandom_range(99);
               2: begin
                  power = 1;
                  k = $urandom_range(9);
                  repeat (k) power = power * DECIMAL_RADIX;
                  w.value = power + $urandom_range(2) - 1;
               end
               3: w.value = 32'h8000_0000 + $urandom_range(4) - 2;
               4: begin
                  power = 1;
                  k = $urandom_range(9);
                  repeat (k) power = power * DECIMAL_RADIX;
                  w.value = $urandom_range(power);
               end
               default: w.value = -$urandom_range(1000, 1);
            endcase
            // leave a burst without idling at the start of every 32 words
            idle_pct = (n % 32 < 8) ? 0 : phase_idle[phase];
            send_word(w, NO_TYPED_ROW, idle_pct);
            if ($urandom_range(39) == 0) drain_chars();
         end
         drain_chars();
      end

      // wait out the last characters, bounded
      start <= 1'b0;
      waited = 0;
      while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time, pending_chars.size());
         failures++;
      end

      $display("Converted %0d numbers (%0d negative), %0d characters compared,",
               numbers_taken, negatives_taken, chars_checked);
      $display("with the sender idle at 0, 85 and 17 percent.");
      if (failures == 0) begin
         $display("integer_to_decimal_ascii verification clean");
      end else begin
         $display("integer_to_decimal_ascii verification failed");
      end
      $finish;
   end

   // end a hung run
   initial begin
      #5_000_000;
      $display("integer_to_decimal_ascii verification failed");
      $finish;
   end

endmodule

>>> integer_to_decimal_ascii.f
hw/rtl/i2da_pkg.sv
hw/rtl/integer_to_decimal_ascii.sv
sim/testbench.sv
